/* sv/motor_lock_detector_unit_macros.svh */
// ----------------------------------------------------------------------------
// Motor lock detector assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef MOTOR_LOCK_DETECTOR_UNIT_MACROS_SVH
`define MOTOR_LOCK_DETECTOR_UNIT_MACROS_SVH

// Same-cycle implication.
`define MLD_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define MLD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* sv/mld_pkg.sv */
// ----------------------------------------------------------------------------
// Motor lock detector package
// Shared types, register map and helper function.
// ----------------------------------------------------------------------------
package mld_pkg;

    localparam int TIME_WIDTH_DEF = 32;
    localparam int ADDR_W         = 5;
    localparam int DATA_W         = 32;
    localparam int REG_IDX_W      = ADDR_W - 2;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_DUTY_THR   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SPEED_THR  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_TRIP_DUR   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_CLEAR_DUR  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LATCH_MODE = 3'd4;

    // Reset values
    localparam logic [15:0] DUTY_THR_RST   = 16'd16384;
    localparam logic [14:0] SPEED_THR_RST  = 15'd10;
    localparam logic [15:0] TRIP_DUR_RST   = 16'd500;
    localparam logic [15:0] CLEAR_DUR_RST  = 16'd1000;
    localparam logic        LATCH_MODE_RST = 1'b1;

    // Input actions
    localparam logic ACTION_EVAL  = 1'b0;
    localparam logic ACTION_RESET = 1'b1;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_SUSPECT = 2'd1,
        MODE_TRIPPED = 2'd2
    } t_mode;

    typedef struct packed {
        logic [15:0] duty_lock_min;
        logic [14:0] speed_threshold;
        logic [15:0] trip_duration;
        logic [15:0] clear_duration;
        logic        latch_mode;
    } t_cfg;

    // Exact magnitude of a 16-bit two's complement value; -32768 gives 32768.
    function automatic logic [16:0] magnitude16(input logic [15:0] v);
        logic [16:0] ext;
        ext = {1'b0, v};
        return v[15] ? (17'h10000 - ext) : ext;
    endfunction

endpackage

/* sv/mld_if.sv */
// ----------------------------------------------------------------------------
// Motor lock detector channel interfaces
// Valid/ready channels for the sample item and the result item.
// ----------------------------------------------------------------------------
interface mld_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic signed [15:0] duty_cmd;
    logic signed [15:0] speed_meas;
    logic [31:0]        time_now;

    modport source (output valid, action, duty_cmd, speed_meas, time_now, input ready);
    modport sink   (input valid, action, duty_cmd, speed_meas, time_now, output ready);
endinterface

interface mld_out_if;
    logic       valid;
    logic       ready;
    logic       is_tripped;
    logic [1:0] mode_now;

    modport source (output valid, is_tripped, mode_now, input ready);
    modport sink   (input valid, is_tripped, mode_now, output ready);
endinterface

/* sv/mld_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Motor lock detector configuration registers
// APB-style register file holding thresholds, durations and latch mode.
// ----------------------------------------------------------------------------
module mld_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mld_pkg::ADDR_W-1:0]  paddr,
    input  logic [mld_pkg::DATA_W-1:0]  pwdata,
    output logic [mld_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output mld_pkg::t_cfg               o_cfg
);
    import mld_pkg::*;

    t_cfg                 r_cfg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.duty_lock_min   <= DUTY_THR_RST;
            r_cfg.speed_threshold <= SPEED_THR_RST;
            r_cfg.trip_duration   <= TRIP_DUR_RST;
            r_cfg.clear_duration  <= CLEAR_DUR_RST;
            r_cfg.latch_mode      <= LATCH_MODE_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_DUTY_THR:   r_cfg.duty_lock_min   <= pwdata[15:0];
                REG_SPEED_THR:  r_cfg.speed_threshold <= pwdata[14:0];
                REG_TRIP_DUR:   r_cfg.trip_duration   <= pwdata[15:0];
                REG_CLEAR_DUR:  r_cfg.clear_duration  <= pwdata[15:0];
                REG_LATCH_MODE: r_cfg.latch_mode      <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_DUTY_THR:   prdata = DATA_W'(r_cfg.duty_lock_min);
            REG_SPEED_THR:  prdata = DATA_W'(r_cfg.speed_threshold);
            REG_TRIP_DUR:   prdata = DATA_W'(r_cfg.trip_duration);
            REG_CLEAR_DUR:  prdata = DATA_W'(r_cfg.clear_duration);
            REG_LATCH_MODE: prdata = DATA_W'(r_cfg.latch_mode);
            default:        prdata = '0;
        endcase
    end

endmodule

/* sv/motor_lock_detector_unit.sv */
// ----------------------------------------------------------------------------
// Motor lock detector
// Tracks idle / suspect / tripped mode from timestamped duty and speed items.
//
//   channel  dir  handshake         contents
//   i_in     in   valid/ready       action, duty_cmd, speed_meas, time_now
//   o_out    out  valid/ready       is_tripped, mode_now
//   cfg      in   psel/penable/...  five registers at byte address 4*index
//
// One item per cycle sustained while o_out is not stalled. The result register
// loads at the edge after an item is accepted unless o_out is stalled, and
// o_out offers the result from there. The mode update is one compare-and-select
// pass between the input register and the result register.
// Reset (i_rst_n low, synchronous) empties both registers and puts the
// detector in idle. A stalled o_out holds the result register, and the input
// register still takes one more item before i_in.ready drops.
// ----------------------------------------------------------------------------
`include "motor_lock_detector_unit_macros.svh"

module motor_lock_detector_unit #(
    parameter int TIME_WIDTH = mld_pkg::TIME_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    mld_in_if.sink                      i_in,
    mld_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mld_pkg::ADDR_W-1:0]  paddr,
    input  logic [mld_pkg::DATA_W-1:0]  pwdata,
    output logic [mld_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import mld_pkg::*;

    t_cfg cfg;

    mld_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Input register
    logic        r_in_valid;
    logic        r_in_action;
    logic [15:0] r_in_duty;
    logic [15:0] r_in_speed;
    logic [31:0] r_in_time;

    // Detector state
    t_mode                 r_mode, n_mode;
    logic [TIME_WIDTH-1:0] r_susp_start, n_susp_start;
    logic                  r_clr_act, n_clr_act;
    logic [TIME_WIDTH-1:0] r_clr_start, n_clr_start;

    // Result register
    logic       r_out_valid;
    logic       r_out_tripped;
    logic [1:0] r_out_mode;

    logic                  in_fire;
    logic                  advance;
    logic                  proc;
    logic [TIME_WIDTH-1:0] now;
    logic [TIME_WIDTH-1:0] susp_elapsed;
    logic [TIME_WIDTH-1:0] clr_elapsed;
    logic [16:0]           duty_mag;
    logic [16:0]           speed_mag;
    logic                  lock;

    assign advance    = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_in_valid || advance;
    assign in_fire    = i_in.valid && i_in.ready;
    assign proc       = r_in_valid && advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_action <= i_in.action;
            r_in_duty   <= i_in.duty_cmd;
            r_in_speed  <= i_in.speed_meas;
            r_in_time   <= i_in.time_now;
        end
    end

    assign now          = TIME_WIDTH'(r_in_time);
    assign susp_elapsed = now - r_susp_start;
    assign clr_elapsed  = now - r_clr_start;
    assign duty_mag     = magnitude16(r_in_duty);
    assign speed_mag    = magnitude16(r_in_speed);
    assign lock         = (duty_mag >= {1'b0, cfg.duty_lock_min}) &&
                          (speed_mag <= {2'b00, cfg.speed_threshold});

    always_comb begin
        n_mode       = r_mode;
        n_susp_start = r_susp_start;
        n_clr_act    = r_clr_act;
        n_clr_start  = r_clr_start;
        if (r_in_action == ACTION_RESET) begin
            n_mode       = MODE_IDLE;
            n_susp_start = now;
            n_clr_act    = 1'b0;
            n_clr_start  = now;
        end else begin
            unique case (r_mode)
                MODE_SUSPECT: begin
                    if (!lock) begin
                        n_mode = MODE_IDLE;
                    end else if (susp_elapsed > TIME_WIDTH'(cfg.trip_duration)) begin
                        n_mode    = MODE_TRIPPED;
                        n_clr_act = 1'b0;
                    end
                end
                MODE_TRIPPED: begin
                    if (!cfg.latch_mode) begin
                        if (lock) begin
                            n_clr_act = 1'b0;
                        end else if (!r_clr_act) begin
                            // condition just went false: start the clear timer
                            n_clr_act   = 1'b1;
                            n_clr_start = now;
                        end else if (clr_elapsed > TIME_WIDTH'(cfg.clear_duration)) begin
                            n_mode    = MODE_IDLE;
                            n_clr_act = 1'b0;
                        end
                    end
                end
                default: begin
                    // idle, and the unused code handled as idle
                    if (lock) begin
                        n_mode       = MODE_SUSPECT;
                        n_susp_start = now;
                    end else begin
                        n_mode = MODE_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_IDLE;
            r_susp_start <= '0;
            r_clr_act    <= 1'b0;
            r_clr_start  <= '0;
        end else if (proc) begin
            r_mode       <= n_mode;
            r_susp_start <= n_susp_start;
            r_clr_act    <= n_clr_act;
            r_clr_start  <= n_clr_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_out_tripped <= (n_mode == MODE_TRIPPED);
            r_out_mode    <= n_mode;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.is_tripped = r_out_tripped;
    assign o_out.mode_now   = r_out_mode;

    `MLD_ASSERT(a_clr_only_tripped, r_clr_act, r_mode == MODE_TRIPPED, "clear timer outside tripped")
    `MLD_ASSERT_NEXT(a_latch_holds, proc && r_mode == MODE_TRIPPED && cfg.latch_mode && r_in_action == ACTION_EVAL, r_mode == MODE_TRIPPED, "latched trip released")
    `MLD_ASSERT_NEXT(a_no_idle_trip, proc && r_mode == MODE_IDLE, r_mode != MODE_TRIPPED, "idle jumped to tripped")
    `MLD_ASSERT(a_ready_when_empty, !r_out_valid, i_in.ready, "input stalled with empty result register")
    `MLD_ASSERT_NEXT(a_result_after_proc, proc, r_out_valid, "processed item produced no result")

endmodule

/* tb/tb_motor_lock_detector_unit.sv */
// ----------------------------------------------------------------------------
// Motor lock detector testbench
// Drives duty/speed samples and reset requests through the valid/ready input
// channel, programs the registers over APB with read-back, and checks every
// result against the table's mode or a cycle-free idle/suspect/tripped model.
// A directed table comes first, then random phases with changing settings.
// ----------------------------------------------------------------------------
module tb_motor_lock_detector_unit;
    import mld_pkg::*;

    localparam int ITEMS_PER_PHASE = 116;
    localparam int NUM_PHASES      = 8;
    localparam int DRAIN_CYCLES    = 8;
    localparam int LIMIT_TIME      = 4_800_000;
    localparam int SCRIPT_ROWS     = 36;

    // Indexes past the register map; writes there must leave everything alone
    localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef enum logic { ROW_SAMPLE, ROW_WRITE } t_row_kind;

    // For ROW_WRITE rows, stamp carries the register data
    typedef struct packed {
        t_row_kind            kind;
        logic [REG_IDX_W-1:0] ridx;
        logic                 act;
        logic [15:0]          duty;
        logic [15:0]          speed;
        logic [31:0]          stamp;
        logic                 typed;
        t_mode                want;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    mld_in_if  in_if();
    mld_out_if out_if();

    motor_lock_detector_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Detector model state
    t_cfg        det_cfg;
    t_mode       det_mode;
    logic [31:0] lock_since;
    logic        clear_armed;
    logic [31:0] clear_since;

    t_mode pending_modes[$];
    int    mismatches;
    bit    steady_phase;
    bit    lock_run;
    logic [31:0] clock_ms;

    t_row script [SCRIPT_ROWS] = '{
        // reset settings: duty 16384, speed 10, trip 500, clear 1000, latched
        '{ROW_SAMPLE, 3'd0, ACTION_EVAL,  16'h0000, 16'h0000, 32'd0,        1'b1, MODE_IDLE},
        '{ROW_SAMPLE, 3'd0, ACTION_EVAL,  16'h4000, 16'h000A, 32'd100,      1'b1, MODE_SUSPECT},
        '{ROW_SAMPLE, 3'd0, ACTION_EVAL,  16'h8000, 16'hFFF6, 32'd600,      1'b1, MODE_SUSPECT},
        '{ROW_SAMPLE, 3'd0, ACTION_EVAL,  16'h7FFF, 16'h0000, 32'd601,      1'b1, MODE_TRIPPED},
        '{ROW_SAMPLE, 3'd0, ACTION_EVAL,  16'h0000, 16'h7FFF, 32'd5000,     1'b1, MODE_TRIPPED},
        '{ROW_SAMPLE, 3'd0, ACTION_RESET, 16'h8000, 16'h8000, 32'hFFFFFFFF, 1'b1, MODE_IDLE},
        '{ROW_SAMPLE, 3'd0, ACTION_EVAL,  16'h8000, 16'h000B, 32'd0,        1'b1, MODE_IDLE},
        '{ROW_SAMPLE, 3'd0, ACTION_EVAL,  16'h3FFF, 16'h0000, 32'd1,        1'b1, MODE_IDLE},
        '{ROW_SAMPLE, 3'd0, ACTION_EVAL,  16'hC000, 16'h8000, 32'd2,        1'b1, MODE_IDLE},
        // suspect interval spanning the time wrap
        '{ROW_SAMPLE, 3'd0, ACTION_EVAL,  16'hC000, 16'h0005, 32'hFFFFFF00, 1'b1, MODE_SUSPECT},
        '{ROW_SAMPLE, 3'd0, ACTION_EVAL,  16'h4E20, 16'hFFFF, 32'h000000F4, 1'b1, MODE_SUSPECT},
        '{ROW_SAMPLE, 3'd0, ACTION_EVAL,  16'h4E20, 16'hFFFF, 32'h000000F5, 1'b1, MODE_TRIPPED},
        '{ROW_SAMPLE, 3'd0, ACTION_EVAL,  16'h0000, 16'h0000, 32'h00000200, 1'b0, MODE_IDLE},
        '{ROW_SAMPLE, 3'd0, ACTION_RESET, 16'h0000, 16'h0000, 32'h00000300, 1'b1, MODE_IDLE},
        // auto clear, zero durations, masked and ignored writes
        '{ROW_WRITE, REG_LATCH_MODE, 1'b0, 16'h0, 16'h0, 32'hFFFFFFFE,      1'b0, MODE_IDLE},
        '{ROW_WRITE, REG_CLEAR_DUR,  1'b0, 16'h0, 16'h0, 32'h00000000,      1'b0, MODE_IDLE},
        '{ROW_WRITE, REG_TRIP_DUR,   1'b0, 16'h0, 16'h0, 32'h00000000,      1'b0, MODE_IDLE},
        '{ROW_WRITE, REG_SPEED_THR,  1'b0, 16'h0, 16'h0, 32'hFFFFFFFF,      1'b0, MODE_IDLE},
        '{ROW_WRITE, REG_DUTY_THR,   1'b0, 16'h0, 16'h0, 32'h00000000,      1'b0, MODE_IDLE},
        '{ROW_WRITE, REG_SPARE_LO,   1'b0, 16'h0, 16'h0, 32'hFFFFFFFF,      1'b0, MODE_IDLE},
        '{ROW_WRITE, REG_SPARE_HI,   1'b0, 16'h0, 16'h0, 32'hFFFFFFFF,      1'b0, MODE_IDLE},
        '{ROW_SAMPLE, 3'd0, ACTION_EVAL,  16'h0000, 16'h0000, 32'd10,       1'b1, MODE_SUSPECT},
        '{ROW_SAMPLE, 3'd0, ACTION_EVAL,  16'h0000, 16'h0000, 32'd10,       1'b1, MODE_SUSPECT},
        '{ROW_SAMPLE, 3'd0, ACTION_EVAL,  16'h0000, 16'h0000, 32'd11,       1'b1, MODE_TRIPPED},
        '{ROW_SAMPLE, 3'd0, ACTION_EVAL,  16'h0000, 16'h8000, 32'd11,       1'b1, MODE_TRIPPED},
        '{ROW_SAMPLE, 3'd0, ACTION_EVAL,  16'h0000, 16'h8000, 32'd11,       1'b1, MODE_TRIPPED},
        '{ROW_SAMPLE, 3'd0, ACTION_EVAL,  16'h0000, 16'h8000, 32'd12,       1'b1, MODE_IDLE},
        // duty threshold above range: lock never holds
        '{ROW_WRITE, REG_DUTY_THR,   1'b0, 16'h0, 16'h0, 32'h0000FFFF,      1'b0, MODE_IDLE},
        '{ROW_WRITE, REG_TRIP_DUR,   1'b0, 16'h0, 16'h0, 32'hABCDFFFF,      1'b0, MODE_IDLE},
        '{ROW_WRITE, REG_CLEAR_DUR,  1'b0, 16'h0, 16'h0, 32'h0000FFFF,      1'b0, MODE_IDLE},
        '{ROW_WRITE, REG_SPEED_THR,  1'b0, 16'h0, 16'h0, 32'h00008000,      1'b0, MODE_IDLE},
        '{ROW_SAMPLE, 3'd0, ACTION_EVAL,  16'h8000, 16'h0000, 32'd100,      1'b1, MODE_IDLE},
        '{ROW_SAMPLE, 3'd0, ACTION_EVAL,  16'h7FFF, 16'h0000, 32'd150,      1'b0, MODE_IDLE},
        // full-scale threshold: only -1.0 duty reaches it
        '{ROW_WRITE, REG_DUTY_THR,   1'b0, 16'h0, 16'h0, 32'h00008000,      1'b0, MODE_IDLE},
        '{ROW_SAMPLE, 3'd0, ACTION_EVAL,  16'h8000, 16'h0000, 32'd200,      1'b1, MODE_SUSPECT},
        '{ROW_SAMPLE, 3'd0, ACTION_EVAL,  16'h7FFF, 16'h0000, 32'd300,      1'b1, MODE_IDLE}
    };

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_TIME);
        $display("status: fail");
        $finish;
    end

    function automatic logic [16:0] abs_q15(input logic [15:0] v);
        logic [16:0] wide;
        wide = {v[15], v};
        return wide[16] ? -wide : wide;
    endfunction

    // Updates the detector model with one accepted item, returns the new mode
    function automatic t_mode advance_detector(input logic act, input logic [15:0] duty,
                                               input logic [15:0] speed,
                                               input logic [31:0] now);
        logic lock;
        if (act == ACTION_RESET) begin
            det_mode    = MODE_IDLE;
            lock_since  = now;
            clear_armed = 1'b0;
            clear_since = now;
        end else begin
            lock = (abs_q15(duty) >= {1'b0, det_cfg.duty_lock_min}) &&
                   (abs_q15(speed) <= {2'b00, det_cfg.speed_threshold});
            case (det_mode)
                MODE_SUSPECT: begin
                    if (!lock) begin
                        det_mode = MODE_IDLE;
                    end else if (now - lock_since > {16'd0, det_cfg.trip_duration}) begin
                        det_mode    = MODE_TRIPPED;
                        clear_armed = 1'b0;
                    end
                end
                MODE_TRIPPED: begin
                    if (!det_cfg.latch_mode) begin
                        if (lock) begin
                            clear_armed = 1'b0;
                        end else if (!clear_armed) begin
                            clear_armed = 1'b1;
                            clear_since = now;
                        end else if (now - clear_since > {16'd0, det_cfg.clear_duration}) begin
                            det_mode    = MODE_IDLE;
                            clear_armed = 1'b0;
                        end
                    end
                end
                default: begin
                    det_mode = MODE_IDLE;
                    if (lock) begin
                        det_mode   = MODE_SUSPECT;
                        lock_since = now;
                    end
                end
            endcase
        end
        return det_mode;
    endfunction

    function automatic void apply_register(input logic [REG_IDX_W-1:0] idx,
                                           input logic [31:0] val);
        case (idx)
            REG_DUTY_THR:   det_cfg.duty_lock_min   = val[15:0];
            REG_SPEED_THR:  det_cfg.speed_threshold = val[14:0];
            REG_TRIP_DUR:   det_cfg.trip_duration   = val[15:0];
            REG_CLEAR_DUR:  det_cfg.clear_duration  = val[15:0];
            REG_LATCH_MODE: det_cfg.latch_mode      = val[0];
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] register_value(input logic [REG_IDX_W-1:0] idx);
        case (idx)
            REG_DUTY_THR:   return {16'd0, det_cfg.duty_lock_min};
            REG_SPEED_THR:  return {17'd0, det_cfg.speed_threshold};
            REG_TRIP_DUR:   return {16'd0, det_cfg.trip_duration};
            REG_CLEAR_DUR:  return {16'd0, det_cfg.clear_duration};
            REG_LATCH_MODE: return {31'd0, det_cfg.latch_mode};
            default:        return 32'd0;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady_phase) return 0;
        r = $urandom_range(99, 0);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    function automatic logic [15:0] with_sign(input int mag);
        if (mag == 32768 || $urandom_range(1, 0)) return 16'(-mag);
        return 16'(mag);
    endfunction

    // Duty magnitude on the requested side of the threshold, often right at it
    function automatic logic [15:0] pick_duty(input bit want_lock);
        int thr;
        int mag;
        thr = int'(det_cfg.duty_lock_min);
        if (thr > 32768 || (!want_lock && thr == 0)) return 16'($urandom());
        if (want_lock) mag = $urandom_range(1, 0) ? thr : $urandom_range(32768, thr);
        else           mag = $urandom_range(1, 0) ? thr - 1 : $urandom_range(thr - 1, 0);
        return with_sign(mag);
    endfunction

    function automatic logic [15:0] pick_speed(input bit want_lock);
        int thr;
        int mag;
        thr = int'(det_cfg.speed_threshold);
        if (want_lock) mag = $urandom_range(1, 0) ? thr : $urandom_range(thr, 0);
        else           mag = $urandom_range(1, 0) ? thr + 1 : $urandom_range(32768, thr + 1);
        return with_sign(mag);
    endfunction

    // Time advance scaled to the duration that currently matters
    function automatic logic [31:0] time_step(input bit want_lock);
        int span;
        int r;
        span = want_lock ? int'(det_cfg.trip_duration) : int'(det_cfg.clear_duration);
        r = $urandom_range(99, 0);
        if (r < 60) return $urandom_range(span / 4 + 1, 0);
        if (r < 85) return (span == 0) ? $urandom_range(1, 0) : span - 1 + $urandom_range(2, 0);
        if (r < 95) return 32'd0;
        return $urandom();
    endfunction

    task automatic send_item(input logic act, input logic [15:0] duty,
                             input logic [15:0] speed, input logic [31:0] stamp,
                             input int gap, input logic typed, input t_mode want);
        t_mode next_mode;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.action     <= act;
        in_if.duty_cmd   <= duty;
        in_if.speed_meas <= speed;
        in_if.time_now   <= stamp;
        do @(posedge i_clk); while (!in_if.ready);
        next_mode = advance_detector(act, duty, speed, stamp);
        pending_modes.push_back(typed ? want : next_mode);
    endtask

    // Waits for the block to drain, writes one register, then reads it back
    task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
        logic [31:0] rd;
        in_if.valid <= 1'b0;
        while (pending_modes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        apply_register(idx, val);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx <= REG_LATCH_MODE && rd !== register_value(idx)) begin
            $display("%0t: register %0d read back expected %h got %h",
                     $time, idx, register_value(idx), rd);
            mismatches++;
        end
    endtask

    task automatic configure_phase(input int ph);
        logic [15:0] duty_thr;
        logic [14:0] speed_thr;
        logic [15:0] trip;
        logic [15:0] clr;
        logic        latch;
        logic [31:0] junk;
        case (ph)
            0: begin
                duty_thr = 16'd0; speed_thr = 15'h7FFF; trip = 16'd0; clr = 16'd0;
                latch = 1'b0;
            end
            1: begin
                duty_thr = 16'h8000; speed_thr = 15'd0; trip = 16'hFFFF; clr = 16'hFFFF;
                latch = 1'b0;
            end
            default: begin
                duty_thr  = ($urandom_range(7, 0) == 0) ? 16'($urandom_range(65535, 32769))
                                                        : 16'($urandom_range(32768, 0));
                speed_thr = $urandom_range(3, 0) ? 15'($urandom_range(300, 0))
                                                 : 15'($urandom());
                trip      = $urandom_range(3, 0) ? 16'($urandom_range(400, 0))
                                                 : 16'($urandom());
                clr       = $urandom_range(3, 0) ? 16'($urandom_range(400, 0))
                                                 : 16'($urandom());
                latch     = 1'($urandom());
            end
        endcase
        junk = $urandom_range(1, 0) ? $urandom() : 32'd0;
        cfg_write(REG_DUTY_THR,   {junk[31:16], duty_thr});
        cfg_write(REG_SPEED_THR,  {junk[31:15], speed_thr});
        cfg_write(REG_TRIP_DUR,   {junk[31:16], trip});
        cfg_write(REG_CLEAR_DUR,  {junk[31:16], clr});
        cfg_write(REG_LATCH_MODE, {junk[31:1], latch});
    endtask

    // Result receiver with random stalls
    initial begin
        out_if.ready = 1'b0;
        forever begin
            out_if.ready <= 1'b1;
            repeat ($urandom_range(12, 1)) @(posedge i_clk);
            if (!steady_phase && $urandom_range(2, 0) == 0) begin
                out_if.ready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_mode want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_modes.size() == 0) begin
                $display("%0t: unexpected result mode_now=%0d is_tripped=%0b",
                         $time, out_if.mode_now, out_if.is_tripped);
                mismatches++;
            end else begin
                want = pending_modes.pop_front();
                if (out_if.mode_now !== want) begin
                    $display("%0t: mode_now expected %0d got %0d",
                             $time, want, out_if.mode_now);
                    mismatches++;
                end
                if (out_if.is_tripped !== (want == MODE_TRIPPED)) begin
                    $display("%0t: is_tripped expected %0b got %0b",
                             $time, want == MODE_TRIPPED, out_if.is_tripped);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        int r;
        mismatches       = 0;
        steady_phase     = 1'b0;
        lock_run         = 1'b0;
        clock_ms         = 32'd0;
        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        in_if.valid      = 1'b0;
        in_if.action     = ACTION_EVAL;
        in_if.duty_cmd   = '0;
        in_if.speed_meas = '0;
        in_if.time_now   = '0;
        det_cfg     = '{DUTY_THR_RST, SPEED_THR_RST, TRIP_DUR_RST, CLEAR_DUR_RST, LATCH_MODE_RST};
        det_mode    = MODE_IDLE;
        lock_since  = '0;
        clear_armed = 1'b0;
        clear_since = '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[k]) begin
            if (script[k].kind == ROW_WRITE)
                cfg_write(script[k].ridx, script[k].stamp);
            else
                send_item(script[k].act, script[k].duty, script[k].speed, script[k].stamp,
                          pick_gap(), script[k].typed, script[k].want);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            configure_phase(ph);
            steady_phase = (ph % 3 == 2);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                r = $urandom_range(99, 0);
                if (r < 4) begin
                    send_item(ACTION_RESET, 16'($urandom()), 16'($urandom()), clock_ms,
                              pick_gap(), 1'b0, MODE_IDLE);
                end else if (r < 16) begin
                    // unshaped samples, sometimes with a jump in time
                    clock_ms = (r < 8) ? $urandom() : clock_ms + $urandom_range(40, 0);
                    send_item(ACTION_EVAL, 16'($urandom()), 16'($urandom()), clock_ms,
                              pick_gap(), 1'b0, MODE_IDLE);
                end else begin
                    if ($urandom_range(5, 0) == 0) lock_run = !lock_run;
                    clock_ms = clock_ms + time_step(lock_run);
                    send_item(ACTION_EVAL, pick_duty(lock_run), pick_speed(lock_run),
                              clock_ms, pick_gap(), 1'b0, MODE_IDLE);
                end
            end
            steady_phase = 1'b0;
        end

        in_if.valid <= 1'b0;
        while (pending_modes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
